// File: sv/vdk3_pkg.sv
// Package for the K=3, rate 1/2 hard-decision Viterbi decoder.
// Holds the shared types, widths, constants and trellis helper functions.
// Has no dependencies.
`timescale 1ns / 1ps

package vdk3_pkg;

  // Trellis and field widths.
  localparam int NUM_STATES  = 4;
  localparam int STATE_W     = 2;
  localparam int METRIC_W    = 8;
  localparam int BM_W        = 2;
  localparam int CNT_W       = 7;
  localparam int DECODED_W   = 64;
  localparam int IN_TDATA_W  = 8;
  localparam int OUT_TDATA_W = 80;

  // Metric marking a state that the trellis has not reached yet.
  localparam logic [METRIC_W-1:0] METRIC_UNREACHED   = 8'hFF;
  localparam logic [CNT_W-1:0]    FRAME_LENGTH_RESET = 7'd64;

  typedef logic [METRIC_W-1:0]   metric_t;
  typedef logic [STATE_W-1:0]    state_t;
  typedef logic [BM_W-1:0]       bm_t;
  typedef metric_t [NUM_STATES-1:0] metric_vec_t;

  // Winner of the end-of-frame search.
  typedef struct packed {
    state_t  best_state;
    metric_t best_metric;
  } best_t;

  // Hamming distance between the received pair and the branch output from prev to nxt.
  // A state is (previous data bit << 1) | newest data bit.
  function automatic bm_t branch_metric(state_t prev, state_t nxt, logic r0, logic r1);
    logic e0;
    logic e1;
    e0 = nxt[0] ^ prev[1];
    e1 = nxt[0] ^ prev[0] ^ prev[1];
    return {1'b0, e0 ^ r0} + {1'b0, e1 ^ r1};
  endfunction

  // Metric add that sticks at the unreachable value.
  function automatic metric_t sat_add(metric_t a, bm_t b);
    logic [METRIC_W:0] s;
    s = {1'b0, a} + {{(METRIC_W + 1 - BM_W){1'b0}}, b};
    if (s > {1'b0, METRIC_UNREACHED}) begin
      return METRIC_UNREACHED;
    end
    return s[METRIC_W-1:0];
  endfunction

endpackage

// File: sv/viterbi_decoder_k3_rate_half_core.sv
// Hard-decision Viterbi decoder, K=3, rate 1/2, generators 7 and 5 (octal).
// Throughput: one code pair per cycle; a frame-ending pair waits while a result is stalled.
// The four ACS lanes do one trellis step per cycle; the last pair loads the output register.
// A pair that does not end a frame is taken even while a result waits downstream.
// Reset (rst_n low, synchronous): trellis back to state 0, pair count zero, output empty,
// frame length back to 64.
`timescale 1ns / 1ps

module viterbi_decoder_k3_rate_half_core #(
  parameter int MAX_FRAME = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  // Configuration: frame length.
  input  logic        cfg_wr_en,
  input  logic [6:0]  cfg_wr_data,
  // Input stream. tdata: [0] code_first, [1] code_second, [7:2] zero.
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,
  // Result stream. tdata: [63:0] decoded_bits, [71:64] best_metric,
  // [73:72] best_state, [79:74] zero.
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [79:0] out_tdata
);

  localparam int PATH_W = MAX_FRAME;
  localparam int POS_W  = $clog2(MAX_FRAME);
  localparam int CNT_W  = vdk3_pkg::CNT_W;
  localparam int NS     = vdk3_pkg::NUM_STATES;
  localparam logic [CNT_W-1:0] MAX_LEN = CNT_W'(MAX_FRAME);

  // Trellis state.
  vdk3_pkg::metric_vec_t pm_r,   pm_nxt;
  logic [PATH_W-1:0]     path_r   [NS];
  logic [PATH_W-1:0]     path_nxt [NS];
  logic [CNT_W-1:0]      cnt_r,  cnt_nxt;
  logic [CNT_W-1:0]      frame_len_r;

  // Result register.
  logic                  out_valid_r, out_valid_nxt;
  logic [vdk3_pkg::OUT_TDATA_W-1:0] out_data_r, out_data_nxt;

  vdk3_pkg::metric_vec_t pm_step;
  logic [PATH_W-1:0]     path_step [NS];
  vdk3_pkg::best_t       best;
  logic [CNT_W-1:0]      eff_len;
  logic [CNT_W-1:0]      cnt_inc;
  logic                  frame_end;
  logic                  in_xfer;
  logic [vdk3_pkg::DECODED_W-1:0] decoded;

  vdk3_acs #(
    .PATH_W (PATH_W),
    .POS_W  (POS_W)
  ) u_acs (
    .pm_i   (pm_r),
    .path_i (path_r),
    .r0_i   (in_tdata[0]),
    .r1_i   (in_tdata[1]),
    .pos_i  (cnt_r[POS_W-1:0]),
    .pm_o   (pm_step),
    .path_o (path_step)
  );

  vdk3_best u_best (
    .pm_i   (pm_step),
    .best_o (best)
  );

  // Frame length clamped into one to MAX_FRAME.
  always_comb begin
    if (frame_len_r == '0) begin
      eff_len = CNT_W'(1);
    end else if (frame_len_r > MAX_LEN) begin
      eff_len = MAX_LEN;
    end else begin
      eff_len = frame_len_r;
    end
  end

  assign cnt_inc   = cnt_r + CNT_W'(1);
  assign frame_end = (cnt_inc >= eff_len);

  // Only a frame-ending pair needs room in the output register.
  assign in_tready = !out_valid_r || out_tready || !frame_end;
  assign in_xfer   = in_tvalid && in_tready;

  // Survivor widened to the full decoded field.
  always_comb begin
    decoded = '0;
    decoded[PATH_W-1:0] = path_step[best.best_state];
  end

  // Trellis update; a frame end restarts in state 0.
  always_comb begin
    pm_nxt   = pm_r;
    path_nxt = path_r;
    cnt_nxt  = cnt_r;
    if (in_xfer) begin
      if (frame_end) begin
        for (int s = 0; s < NS; s++) begin
          pm_nxt[s]   = (s == 0) ? '0 : vdk3_pkg::METRIC_UNREACHED;
          path_nxt[s] = '0;
        end
        cnt_nxt = '0;
      end else begin
        pm_nxt   = pm_step;
        path_nxt = path_step;
        cnt_nxt  = cnt_inc;
      end
    end
  end

  // Output register load and drain.
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (in_xfer && frame_end) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = {6'b0, best.best_state, best.best_metric, decoded};
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s < NS; s++) begin
        pm_r[s]   <= (s == 0) ? '0 : vdk3_pkg::METRIC_UNREACHED;
        path_r[s] <= '0;
      end
      cnt_r       <= '0;
      frame_len_r <= vdk3_pkg::FRAME_LENGTH_RESET;
      out_valid_r <= 1'b0;
    end else begin
      pm_r        <= pm_nxt;
      path_r      <= path_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        frame_len_r <= cfg_wr_data;
      end
    end
  end

  // Result payload needs no reset.
  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

// File: sv/vdk3_acs.sv
// Four parallel add-compare-select lanes with register-exchange survivor update.
// Depends on vdk3_pkg.
`timescale 1ns / 1ps

module vdk3_acs #(
  parameter int PATH_W = 64,
  parameter int POS_W  = 6
) (
  input  vdk3_pkg::metric_vec_t pm_i,
  input  logic [PATH_W-1:0]     path_i [vdk3_pkg::NUM_STATES],
  input  logic                  r0_i,
  input  logic                  r1_i,
  input  logic [POS_W-1:0]      pos_i,
  output vdk3_pkg::metric_vec_t pm_o,
  output logic [PATH_W-1:0]     path_o [vdk3_pkg::NUM_STATES]
);

  for (genvar s = 0; s < vdk3_pkg::NUM_STATES; s++) begin : g_lane
    localparam vdk3_pkg::state_t CUR = vdk3_pkg::state_t'(s);
    localparam vdk3_pkg::state_t LO  = vdk3_pkg::state_t'(s / 2);
    localparam vdk3_pkg::state_t HI  = LO | 2'b10;
    localparam logic NEW_BIT = 1'(s % 2);

    vdk3_pkg::metric_t m_lo;
    vdk3_pkg::metric_t m_hi;
    logic              pick_hi;
    logic [PATH_W-1:0] sel_path;

    // Candidate metrics from both predecessors; the lower-numbered one wins a tie.
    assign m_lo    = vdk3_pkg::sat_add(pm_i[LO], vdk3_pkg::branch_metric(LO, CUR, r0_i, r1_i));
    assign m_hi    = vdk3_pkg::sat_add(pm_i[HI], vdk3_pkg::branch_metric(HI, CUR, r0_i, r1_i));
    assign pick_hi = (m_hi < m_lo);

    assign pm_o[s]  = pick_hi ? m_hi : m_lo;
    assign sel_path = pick_hi ? path_i[HI] : path_i[LO];

    // Append this state's newest data bit at the current frame position.
    assign path_o[s] = sel_path | ({{(PATH_W-1){1'b0}}, NEW_BIT} << pos_i);
  end

endmodule

// File: sv/vdk3_best.sv
// End-of-frame search for the state with the lowest path metric.
// Depends on vdk3_pkg.
`timescale 1ns / 1ps

module vdk3_best (
  input  vdk3_pkg::metric_vec_t pm_i,
  output vdk3_pkg::best_t       best_o
);

  // Strict less-than keeps the lower-numbered state on a tie.
  always_comb begin
    best_o.best_state  = '0;
    best_o.best_metric = pm_i[0];
    for (int i = 1; i < vdk3_pkg::NUM_STATES; i++) begin
      if (pm_i[i] < best_o.best_metric) begin
        best_o.best_state  = vdk3_pkg::state_t'(i);
        best_o.best_metric = pm_i[i];
      end
    end
  end

endmodule

// File: sv/vdk3_checker.sv
// Port-level checker for the Viterbi decoder core, attached by bind.
// Depends only on the top level's ports.
`timescale 1ns / 1ps

module vdk3_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [79:0] out_tdata
);

  // The output is empty right after reset.
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

  // A stalled result holds its data.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result changed");

  // A new result only follows an input transfer.
  a_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(in_tvalid && in_tready))
    else $error("result appeared without an input transfer");

  // A path metric never exceeds two per decoded bit, and padding stays zero.
  a_metric: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[71:64] <= 8'd128) && (out_tdata[79:74] == 6'b0))
    else $error("result metric out of range");

endmodule

bind viterbi_decoder_k3_rate_half_core vdk3_checker u_vdk3_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
